// ----- rtl/core/wot_pkg.sv -----
// shared types and constants of the winograd output transform
package wot_pkg;

    // widths of the arithmetic
    localparam int PARTIAL_W   = 26;
    localparam int VALUE_W     = 28;

    // tile geometry
    localparam int ELEM_W       = 4;
    localparam int ROW_SUMS     = 8;
    localparam int OUT_PER_TILE = 4;
    localparam int TILE_IDX_W   = 9;
    localparam int COORD_W      = 10;

    // cropping limit and compare width
    localparam int MAX_OUT_DIM  = 1024;
    localparam int DIM_CMP_W    = 14;

    // tile queue between front and back
    localparam int QUEUE_DEPTH  = 2;

    // configuration port
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 11;
    localparam int TILE_CNT_W   = 10;
    localparam int DIM_W        = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT   = 4'd3;

    typedef logic signed [PARTIAL_W-1:0] partial_t;
    typedef logic signed [VALUE_W-1:0]   value_t;

    // one finished 2x2 tile, values in order (0,0),(0,1),(1,0),(1,1)
    typedef struct packed {
        logic [TILE_IDX_W-1:0]        tile_row;
        logic [TILE_IDX_W-1:0]        tile_col;
        value_t [OUT_PER_TILE-1:0]    value;
    } wot_tile_t;

endpackage

// ----- rtl/core/wot_front.sv -----
// front end: takes samples, builds row sums, forms the 2x2 tile
module wot_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    input  logic                                s_frame_start,
    input  logic [wot_pkg::TILE_CNT_W-1:0]      tiles_across,
    input  logic [wot_pkg::TILE_CNT_W-1:0]      tiles_down,
    output logic                                push_valid,
    input  logic                                push_ready,
    output wot_pkg::wot_tile_t                  push_tile
);
    import wot_pkg::*;

    logic                   accept;
    logic [ELEM_W-1:0]      elem_reg, elem_next, elem_cur;
    logic [TILE_IDX_W-1:0]  col_reg, col_next, col_cur, col_inc;
    logic [TILE_IDX_W-1:0]  row_reg, row_next, row_cur, row_inc;
    logic [1:0]             cur_row, cur_col;
    logic                   tile_done;
    partial_t               x;
    partial_t               part_reg [ROW_SUMS];
    partial_t               stg_part_reg [ROW_SUMS];
    logic                   stg_valid_reg, stg_valid_next;
    logic [TILE_IDX_W-1:0]  stg_row_reg, stg_col_reg;

    assign accept  = s_valid && s_ready;
    assign s_ready = !stg_valid_reg || push_ready;

    // position of this sample, frame start puts it at the origin
    assign elem_cur  = s_frame_start ? '0 : elem_reg;
    assign col_cur   = s_frame_start ? '0 : col_reg;
    assign row_cur   = s_frame_start ? '0 : row_reg;
    assign cur_row   = elem_cur[3:2];
    assign cur_col   = elem_cur[1:0];
    assign tile_done = (elem_cur == '1);
    assign x         = PARTIAL_W'(s_sample);

    // tile position advance
    assign col_inc = col_cur + 1'b1;
    assign row_inc = row_cur + 1'b1;

    always_comb begin
        elem_next = elem_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept) begin
            elem_next = elem_cur + 1'b1;
            col_next  = col_cur;
            row_next  = row_cur;
            if (tile_done) begin
                if (col_inc == '0 || {1'b0, col_inc} >= tiles_across) begin
                    col_next = '0;
                    if (row_inc == '0 || {1'b0, row_inc} >= tiles_down) begin
                        row_next = '0;
                    end else begin
                        row_next = row_inc;
                    end
                end else begin
                    col_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            elem_reg <= elem_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    // row sums: each tile row owns two accumulators
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < ROW_SUMS / 2; k++) begin
                if (cur_row == k[1:0]) begin
                    case (cur_col)
                        2'd0: begin
                            part_reg[2*k]   <= x;
                            part_reg[2*k+1] <= '0;
                        end
                        2'd1: begin
                            part_reg[2*k]   <= part_reg[2*k] + x;
                            part_reg[2*k+1] <= part_reg[2*k+1] + x;
                        end
                        2'd2: begin
                            part_reg[2*k]   <= part_reg[2*k] + x;
                            part_reg[2*k+1] <= part_reg[2*k+1] - x;
                        end
                        default: begin
                            part_reg[2*k+1] <= part_reg[2*k+1] - x;
                        end
                    endcase
                end
            end
        end
    end

    // snapshot stage holding a finished tile's row sums
    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (accept && tile_done) begin
            stg_valid_next = 1'b1;
        end else if (push_ready) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && tile_done) begin
            for (int k = 0; k < ROW_SUMS - 1; k++) begin
                stg_part_reg[k] <= part_reg[k];
            end
            stg_part_reg[ROW_SUMS-1] <= part_reg[ROW_SUMS-1] - x;
            stg_row_reg <= row_cur;
            stg_col_reg <= col_cur;
        end
    end

    // column combination of the row sums
    always_comb begin
        push_tile.tile_row = stg_row_reg;
        push_tile.tile_col = stg_col_reg;
        for (int i = 0; i < 2; i++) begin
            push_tile.value[i]   = VALUE_W'(stg_part_reg[i])
                                 + VALUE_W'(stg_part_reg[2+i])
                                 + VALUE_W'(stg_part_reg[4+i]);
            push_tile.value[2+i] = VALUE_W'(stg_part_reg[2+i])
                                 - VALUE_W'(stg_part_reg[4+i])
                                 - VALUE_W'(stg_part_reg[6+i]);
        end
    end

    assign push_valid = stg_valid_reg;

endmodule

// ----- rtl/core/wot_fifo.sv -----
// short tile queue between front and back
module wot_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  wot_pkg::wot_tile_t  push_tile,
    output logic                pop_valid,
    input  logic                pop,
    output wot_pkg::wot_tile_t  pop_tile
);
    import wot_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    wot_tile_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_tile   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_tile;
        end
    end

endmodule

// ----- rtl/core/wot_back.sv -----
// back end: crops a tile and sends its values one beat at a time
module wot_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                head_valid,
    output logic                                head_pop,
    input  wot_pkg::wot_tile_t                  head_tile,
    input  logic [wot_pkg::DIM_W-1:0]           out_width,
    input  logic [wot_pkg::DIM_W-1:0]           out_height,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wot_pkg::COORD_W-1:0]         m_out_row,
    output logic [wot_pkg::COORD_W-1:0]         m_out_col,
    output logic signed [wot_pkg::VALUE_W-1:0]  m_out_value,
    output logic                                m_last_of_tile
);
    import wot_pkg::*;

    logic [OUT_PER_TILE-1:0]  keep, remain, pick, remain_after;
    logic [OUT_PER_TILE-1:0]  sent_reg, sent_next;
    logic [1:0]               sel;
    logic [COORD_W-1:0]       y [2];
    logic [COORD_W-1:0]       xc [2];
    logic [1:0]               row_ok, col_ok;
    logic                     out_load;
    logic                     m_valid_reg;
    logic [COORD_W-1:0]       row_reg, col_reg;
    value_t                   value_reg;
    logic                     last_reg;

    // crop against the configured frame size
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            y[j]  = {head_tile.tile_row, j[0]};
            xc[j] = {head_tile.tile_col, j[0]};
            row_ok[j] = ({{(DIM_CMP_W-COORD_W){1'b0}}, y[j]}
                            < {{(DIM_CMP_W-DIM_W){1'b0}}, out_height})
                     && ({{(DIM_CMP_W-COORD_W){1'b0}}, y[j]} < DIM_CMP_W'(MAX_OUT_DIM));
            col_ok[j] = ({{(DIM_CMP_W-COORD_W){1'b0}}, xc[j]}
                            < {{(DIM_CMP_W-DIM_W){1'b0}}, out_width})
                     && ({{(DIM_CMP_W-COORD_W){1'b0}}, xc[j]} < DIM_CMP_W'(MAX_OUT_DIM));
        end
        for (int k = 0; k < OUT_PER_TILE; k++) begin
            keep[k] = row_ok[k / 2] && col_ok[k % 2];
        end
    end

    // lowest position still to send
    assign remain       = keep & ~sent_reg;
    assign pick         = remain & (~remain + 1'b1);
    assign remain_after = remain & ~pick;

    always_comb begin
        sel = '0;
        for (int k = OUT_PER_TILE - 1; k >= 0; k--) begin
            if (remain[k]) begin
                sel = k[1:0];
            end
        end
    end

    assign out_load = head_valid && (remain != '0) && (!m_valid_reg || m_ready);
    assign head_pop = head_valid && ((remain == '0) || (out_load && remain_after == '0));

    always_comb begin
        sent_next = sent_reg;
        if (head_pop) begin
            sent_next = '0;
        end else if (out_load) begin
            sent_next = sent_reg | pick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sent_reg <= sent_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            row_reg   <= y[sel[1]];
            col_reg   <= xc[sel[0]];
            value_reg <= head_tile.value[sel];
            last_reg  <= (remain_after == '0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_row      = row_reg;
    assign m_out_col      = col_reg;
    assign m_out_value    = value_reg;
    assign m_last_of_tile = last_reg;

endmodule

// ----- rtl/core/winograd_output_transform_2x2_3x3.sv -----
// top level of the winograd f(2x2,3x3) output transform
// Takes one 4x4 transformed tile element per cycle (row-major within a tile,
// tiles in raster order) and returns up to four cropped output values per tile,
// each with its pixel row, column and a last-of-tile mark. Input runs at one
// sample per cycle unless stalled; each tile's 16 samples yield at most four
// results, which the back end sends one per cycle while m_ready is high; then
// output does not limit the input rate. Results pass the tile snapshot stage,
// a two-tile queue between the sample side and the result side, and the output
// register; input stalls only when that queue and the snapshot stage are full.
// Configuration registers are written through the cfg port, always ready,
// and must only change while no tile is in flight.
module winograd_output_transform_2x2_3x3 #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wot_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wot_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    input  logic                                s_frame_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wot_pkg::COORD_W-1:0]         m_out_row,
    output logic [wot_pkg::COORD_W-1:0]         m_out_col,
    output logic signed [wot_pkg::VALUE_W-1:0]  m_out_value,
    output logic                                m_last_of_tile
);
    import wot_pkg::*;

    logic [TILE_CNT_W-1:0]  tiles_across_reg, tiles_down_reg;
    logic [DIM_W-1:0]       out_width_reg, out_height_reg;
    logic                   push_valid, push_ready;
    wot_tile_t              push_tile;
    logic                   head_valid, head_pop;
    wot_tile_t              head_tile;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiles_across_reg <= TILE_CNT_W'(1);
            tiles_down_reg   <= TILE_CNT_W'(1);
            out_width_reg    <= DIM_W'(1);
            out_height_reg   <= DIM_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TILES_ACROSS: tiles_across_reg <= cfg_data[TILE_CNT_W-1:0];
                CFG_TILES_DOWN:   tiles_down_reg   <= cfg_data[TILE_CNT_W-1:0];
                CFG_OUT_WIDTH:    out_width_reg    <= cfg_data[DIM_W-1:0];
                CFG_OUT_HEIGHT:   out_height_reg   <= cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sample side
    wot_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_frame_start (s_frame_start),
        .tiles_across  (tiles_across_reg),
        .tiles_down    (tiles_down_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_tile     (push_tile)
    );

    // tile queue
    wot_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tile  (push_tile),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_tile   (head_tile)
    );

    // result side
    wot_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_pop       (head_pop),
        .head_tile      (head_tile),
        .out_width      (out_width_reg),
        .out_height     (out_height_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_out_value    (m_out_value),
        .m_last_of_tile (m_last_of_tile)
    );

endmodule
